[hw/rtl/tccw_pkg.sv]
// Shared types, sizes and codes of the text console cell writer.
// No dependencies; every other RTL file but tccw_cell_ram imports this package.
`default_nettype none
package tccw_pkg;

    // Screen geometry
    localparam int ROWS     = 25;
    localparam int COLS     = 80;
    localparam int TAB_STOP = 4;

    localparam int NCELLS         = ROWS * COLS;
    localparam int LAST_ROW_START = (ROWS - 1) * COLS;
    localparam int LRS_PHASE      = LAST_ROW_START % TAB_STOP;

    localparam int CNT_MAX = (COLS > TAB_STOP) ? COLS : TAB_STOP;

    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CUR_W  = $clog2(NCELLS + 1);
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int CNT_W  = $clog2(CNT_MAX + 1);
    localparam int CELL_W = 16;

    // APB
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_TEXT_ATTR = 3'd0;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // Request and character codes
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL  = 8'd10;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } out_item_t;

    // Cell store access from the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_PUT,
        ST_SCR_COPY,
        ST_SCR_BLANK,
        ST_FINISH
    } ctrl_state_t;

endpackage
`default_nettype wire

[hw/rtl/text_console_cell_writer.sv]
// Text console cell writer top: cfg, ctrl and cell RAM; depends on tccw_pkg.
// Path: a request is taken in idle and decoded in exec; a read then passes read wait,
// a put, tab or newline writes its cells in put, a backspace goes straight to finish,
// and a scroll copies the rows at one memory access per cycle, then blanks the last row.
// Throughput: one item at a time; a new request is taken only once the last is done.
// Reset: a clearing pass zeroes all NCELLS (2000) cells before the first transfer.
`default_nettype none
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data,
    // APB configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [7:0]        text_attr;
    mem_req_t          mem_req;
    logic [CELL_W-1:0] mem_rdata;

    // Attribute register; the user must write it only while the block is idle, the block itself does not enforce this
    tccw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .text_attr (text_attr)
    );

    // Sequencer: owns the cursor and every access to the cell store.
    // Results sit in an output register, so the next transfer can be
    // accepted while the previous result waits.
    tccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .text_attr (text_attr),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // Cell store: {attribute, character} per cell. Row copy during a scroll
    // reads cell i and writes cell i-COLS, so read and write never collide.
    tccw_cell_ram #(
        .DEPTH  (NCELLS),
        .WIDTH  (CELL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

[hw/rtl/tccw_cell_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module tccw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/tccw_cfg.sv]
// APB register block holding the text attribute byte.
// Depends on tccw_pkg.
`default_nettype none
module tccw_cfg
    import tccw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [7:0]         text_attr
);

    logic [7:0] attr_reg;
    logic [7:0] attr_next;
    logic       attr_hit;

    // Registers sit at 4-byte strides; low two bits are ignored
    assign attr_hit = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR[PADDR_W-1:2]);

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && attr_hit)
        begin
            attr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    assign prdata    = attr_hit ? {{(PDATA_W-8){1'b0}}, attr_reg} : '0;
    assign pready    = 1'b1;
    assign text_attr = attr_reg;

endmodule
`default_nettype wire

[hw/rtl/tccw_ctrl.sv]
// Request sequencer: cursor tracking, put/backspace/tab/newline, scroll and
// the clearing pass over the cell store. Depends on tccw_pkg.
`default_nettype none
module tccw_ctrl
    import tccw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic [7:0]        text_attr,
    output mem_req_t               mem_req,
    input  wire logic [CELL_W-1:0] mem_rdata
);

    ctrl_state_t state_reg, state_next;

    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        ch_reg, ch_next;
    logic [CUR_W-1:0]  scr_reg, scr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    in_item_t          req_reg, req_next;
    logic              in_range_reg, in_range_next;
    logic [7:0]        res_char_reg, res_char_next;
    logic [7:0]        res_attr_reg, res_attr_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic accept;
    logic cur_full;
    logic scr_done;
    logic scr_last;
    logic is_bs, is_tab, is_nl;
    logic out_free;

    assign accept   = in_valid && in_ready;
    assign cur_full = (cursor_reg == CUR_W'(NCELLS));
    assign scr_done = (scr_reg == CUR_W'(NCELLS));
    assign scr_last = (scr_reg == CUR_W'(NCELLS - 1));
    assign is_bs    = (req_reg.char_code == CH_BS);
    assign is_tab   = (req_reg.char_code == CH_TAB);
    assign is_nl    = (req_reg.char_code == CH_NL);
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (scr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (req_reg.req_type == REQ_READ)
                begin
                    state_next = ST_READ_WAIT;
                end
                else if (is_bs)
                begin
                    state_next = ST_FINISH;
                end
                else if (is_nl && (cursor_reg >= CUR_W'(LAST_ROW_START)))
                begin
                    state_next = ST_SCR_COPY;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_PUT:
            begin
                if (cur_full)
                begin
                    state_next = ST_SCR_COPY;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCR_COPY:
            begin
                if (scr_done)
                begin
                    state_next = ST_SCR_BLANK;
                end
            end
            ST_SCR_BLANK:
            begin
                if (scr_last)
                begin
                    state_next = (cnt_reg != '0) ? ST_PUT : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory access
    always_comb
    begin
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        scr_next       = scr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        req_next       = req_reg;
        in_range_next  = in_range_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        mem_req.we     = 1'b0;
        mem_req.waddr  = ADDR_W'(cursor_reg);
        mem_req.wdata  = {text_attr, 8'd0};
        mem_req.raddr  = ADDR_W'(scr_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(scr_reg);
                mem_req.wdata = '0;
                scr_next      = scr_last ? '0 : scr_reg + CUR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = in_data;
                end
            end
            ST_EXEC:
            begin
                res_char_next = '0;
                res_attr_next = '0;
                in_range_next = (32'(req_reg.cell_index) < 32'(NCELLS));
                mem_req.raddr = ADDR_W'(req_reg.cell_index);
                scr_next      = CUR_W'(COLS);
                pend_next     = 1'b0;
                ch_next       = 8'd0;
                if (req_reg.req_type == REQ_READ)
                begin
                    // read issued this cycle, data next cycle
                end
                else if (is_bs)
                begin
                    if (cursor_reg != '0)
                    begin
                        cursor_next   = cursor_reg - CUR_W'(1);
                        col_next      = (col_reg == '0) ? COL_W'(COLS - 1)
                                                        : col_reg - COL_W'(1);
                        phase_next    = (phase_reg == '0) ? PH_W'(TAB_STOP - 1)
                                                          : phase_reg - PH_W'(1);
                        mem_req.we    = 1'b1;
                        mem_req.waddr = ADDR_W'(cursor_reg - CUR_W'(1));
                    end
                end
                else if (is_tab)
                begin
                    cnt_next = CNT_W'(TAB_STOP) - CNT_W'(phase_reg);
                end
                else if (is_nl)
                begin
                    // on the last row this is a bare scroll
                    cnt_next = (cursor_reg >= CUR_W'(LAST_ROW_START))
                             ? '0 : CNT_W'(COLS) - CNT_W'(col_reg);
                end
                else
                begin
                    cnt_next = CNT_W'(1);
                    ch_next  = req_reg.char_code;
                end
            end
            ST_READ_WAIT:
            begin
                res_char_next = in_range_reg ? mem_rdata[7:0] : 8'd0;
                res_attr_next = in_range_reg ? mem_rdata[15:8] : 8'd0;
            end
            ST_PUT:
            begin
                if (cur_full)
                begin
                    scr_next  = CUR_W'(COLS);
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ADDR_W'(cursor_reg);
                    mem_req.wdata = {text_attr, ch_reg};
                    cursor_next   = cursor_reg + CUR_W'(1);
                    col_next      = (col_reg == COL_W'(COLS - 1)) ? '0
                                                                  : col_reg + COL_W'(1);
                    phase_next    = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0
                                                                       : phase_reg + PH_W'(1);
                    cnt_next      = cnt_reg - CNT_W'(1);
                end
            end
            ST_SCR_COPY:
            begin
                // Row shift: read cell i, write it one row up when its registered read data returns
                mem_req.we    = pend_reg;
                mem_req.waddr = pend_addr_reg;
                mem_req.wdata = mem_rdata;
                mem_req.raddr = ADDR_W'(scr_reg);
                if (!scr_done)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(scr_reg - CUR_W'(COLS));
                    scr_next       = scr_reg + CUR_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    scr_next  = CUR_W'(LAST_ROW_START);
                end
            end
            ST_SCR_BLANK:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(scr_reg);
                mem_req.wdata = {text_attr, 8'd0};
                scr_next      = scr_reg + CUR_W'(1);
                if (scr_last)
                begin
                    cursor_next = CUR_W'(LAST_ROW_START);
                    col_next    = '0;
                    phase_next  = PH_W'(LRS_PHASE);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.cursor_pos = 11'(cursor_reg);
                    out_data_next.read_char  = res_char_reg;
                    out_data_next.read_attr  = res_attr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cursor_reg    <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            scr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            scr_reg       <= scr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        pend_addr_reg <= pend_addr_next;
        req_reg       <= req_next;
        in_range_reg  <= in_range_next;
        res_char_reg  <= res_char_next;
        res_attr_reg  <= res_attr_next;
        out_data_reg  <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

[verif/tccw_screen_checker.sv]
// Screen checker for the text console cell writer: mirrors the cell store,
// cursor and attribute register, and compares every result transfer.
// Depends on tccw_pkg for the transfer structs and codes.
`timescale 1ns / 100ps
module tccw_screen_checker
    import tccw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 outstanding,
    output int                 scroll_count,
    output int                 cursor_hint
);

    logic [CELL_W-1:0] screen_mem [NCELLS];
    int                text_cursor;
    logic [7:0]        attr_now;
    int                mismatches;
    int                scrolls;
    out_item_t         predicted_replies[$];

    function automatic void shift_rows_up();
        for (int i = 0; i < LAST_ROW_START; i++)
            screen_mem[i] = screen_mem[i + COLS];
        for (int i = LAST_ROW_START; i < NCELLS; i++)
            screen_mem[i] = {attr_now, 8'h00};
        text_cursor = LAST_ROW_START;
        scrolls++;
    endfunction

    function automatic void type_glyph(logic [7:0] ch);
        if (text_cursor >= NCELLS)
            shift_rows_up();
        screen_mem[text_cursor] = {attr_now, ch};
        text_cursor++;
    endfunction

    function automatic void type_blanks(int count);
        for (int i = 0; i < count; i++)
            type_glyph(8'h00);
    endfunction

    // Applies one request to the mirrored screen and returns its reply.
    function automatic out_item_t edit_screen(in_item_t req);
        out_item_t reply;
        int        phase;
        reply = '0;
        if (req.req_type == REQ_READ) begin
            if (req.cell_index < NCELLS) begin
                reply.read_char = screen_mem[req.cell_index][7:0];
                reply.read_attr = screen_mem[req.cell_index][15:8];
            end
        end
        else if (req.char_code == CH_BS) begin
            if (text_cursor != 0) begin
                text_cursor--;
                screen_mem[text_cursor] = {attr_now, 8'h00};
            end
        end
        else if (req.char_code == CH_TAB) begin
            // blank count is fixed up front, a scroll midway does not change it
            phase = text_cursor % TAB_STOP;
            type_blanks(phase == 0 ? TAB_STOP : TAB_STOP - phase);
        end
        else if (req.char_code == CH_NL) begin
            if (text_cursor >= LAST_ROW_START)
                shift_rows_up();
            else
                type_blanks(COLS - text_cursor % COLS);
        end
        else begin
            type_glyph(req.char_code);
        end
        reply.cursor_pos = 11'(text_cursor);
        return reply;
    endfunction

    task automatic flag_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < NCELLS; i++)
                screen_mem[i] = '0;
            text_cursor = 0;
            attr_now    = ATTR_RESET;
            mismatches  = 0;
            scrolls     = 0;
            predicted_replies.delete();
            fail_count   <= 0;
            outstanding  <= 0;
            scroll_count <= 0;
            cursor_hint  <= 0;
        end
        else begin
            // word-aligned decode: low two address bits are ignored
            if (psel && penable && pwrite && pready &&
                paddr[PADDR_W-1:2] == REG_TEXT_ATTR[PADDR_W-1:2])
                attr_now = pwdata[7:0];
            if (in_valid && in_ready)
                predicted_replies.push_back(edit_screen(in_data));
            if (out_valid && out_ready) begin
                if (predicted_replies.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, out_data);
                    mismatches++;
                end
                else begin
                    want = predicted_replies.pop_front();
                    flag_field("cursor_pos", want.cursor_pos, out_data.cursor_pos);
                    flag_field("read_char", want.read_char, out_data.read_char);
                    flag_field("read_attr", want.read_attr, out_data.read_attr);
                end
            end
            fail_count   <= mismatches;
            outstanding  <= predicted_replies.size();
            scroll_count <= scrolls;
            cursor_hint  <= text_cursor;
        end
    end

endmodule

[verif/tb.sv]
// Top of the text console cell writer bench: clock, reset, request and
// APB stimulus, result back-pressure, watchdog and verdict.
// Depends on tccw_pkg, tccw_screen_checker and the RTL top.
`timescale 1ns / 100ps
module tb;
    import tccw_pkg::*;

    localparam int STALL_LIMIT   = 20000; // >> scroll + hold-off + stalls
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 40;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int outstanding;
    int scroll_count;
    int cursor_hint;

    // traffic shaping, percent of cycles each side sits idle
    int send_gap_pct;
    int recv_gap_pct;
    int stim_phase;
    int sent_total;
    int sent_reads;
    logic [7:0] last_attr;

    always #5 clk = ~clk;

    text_console_cell_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tccw_screen_checker screen_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .scroll_count (scroll_count),
        .cursor_hint  (cursor_hint)
    );

    function automatic in_item_t make_req(logic kind, logic [7:0] ch, logic [10:0] idx);
        in_item_t req;
        req.req_type   = kind;
        req.char_code  = ch;
        req.cell_index = idx;
        return req;
    endfunction

    // Random request. Above the last row newlines dominate so the cursor
    // gets to the bottom fast; on the last row mostly tabs and characters,
    // so the row fills and runs over into a scroll.
    function automatic in_item_t random_request(int hint);
        in_item_t req;
        int       pick;
        req  = make_req(REQ_PUT, 8'($urandom_range(0, 255)),
                        11'($urandom_range(0, 2047)));
        pick = $urandom_range(0, 99);
        if (hint < LAST_ROW_START) begin
            if (pick < 40)
                req.char_code = CH_NL;
            else if (pick < 65)
                req.char_code = CH_TAB;
            else if (pick < 70)
                req.char_code = CH_BS;
            else if (pick >= 90)
                req.req_type = REQ_READ;
        end
        else begin
            if (pick < 5)
                req.char_code = CH_NL;
            else if (pick < 50)
                req.char_code = CH_TAB;
            else if (pick < 55)
                req.char_code = CH_BS;
            else if (pick >= 90)
                req.req_type = REQ_READ;
        end
        return req;
    endfunction

    // One request transfer. Valid is not dropped between back-to-back
    // transfers; it only falls when the sender decides to idle.
    task automatic send_request(in_item_t req);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_total++;
        if (req.req_type == REQ_READ)
            sent_reads++;
    endtask

    // Setup then access cycle; the write lands on the edge with pready high.
    task automatic write_attr(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TEXT_ATTR;
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        last_attr  = value;
    endtask

    // Block is idle only once every result is back; a little slack after.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_request(random_request(cursor_hint));
    endtask

    // Result side: random back-pressure, plus one long hold-off at the start
    // of the second random phase so the block fills up and stalls its input.
    initial
    begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_done && stim_phase == 2) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Watchdog: too long without any transfer on either channel.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        stim_phase   <= 0;
        send_gap_pct  = 37;
        recv_gap_pct <= 47;
        sent_total    = 0;
        sent_reads    = 0;
        last_attr     = ATTR_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed edits under the reset attribute. The block runs its
        // clearing pass first; the sender simply waits on ready.
        send_request(make_req(REQ_READ, 8'h00, 11'd0));     // cleared store
        send_request(make_req(REQ_PUT, CH_BS, 11'd0));      // backspace at home: no-op
        send_request(make_req(REQ_PUT, 8'hFF, 11'd0));
        send_request(make_req(REQ_PUT, 8'h00, 11'd0));      // char 0 is printable
        send_request(make_req(REQ_PUT, CH_TAB, 11'd0));     // off a stop: 2 blanks
        send_request(make_req(REQ_PUT, CH_TAB, 11'd0));     // on a stop: full 4
        send_request(make_req(REQ_PUT, CH_BS, 11'd0));
        send_request(make_req(REQ_PUT, 8'h41, 11'h7FF));    // index ignored on put
        send_request(make_req(REQ_PUT, 8'h80, 11'd0));
        send_request(make_req(REQ_PUT, 8'h7F, 11'd0));
        send_request(make_req(REQ_PUT, CH_NL, 11'd0));      // blank to row end
        send_request(make_req(REQ_PUT, CH_NL, 11'd0));      // at column 0: a whole row
        send_request(make_req(REQ_READ, 8'h00, 11'd0));
        send_request(make_req(REQ_READ, CH_BS, 11'd7));     // char ignored on read
        send_request(make_req(REQ_READ, 8'hFF, 11'd9));
        send_request(make_req(REQ_READ, 8'h00, 11'd1999));  // last cell
        send_request(make_req(REQ_READ, 8'h00, 11'd2000));  // first out of range
        send_request(make_req(REQ_READ, 8'h00, 11'h7FF));   // top of the index field
        send_request(make_req(REQ_PUT, 8'h0B, 11'd0));
        wait_idle();

        // Random phase 1: sender idles 37%, receiver 47%, attribute all zero.
        write_attr(8'h00);
        stim_phase <= 1;
        run_random(PHASE_ITEMS);
        wait_idle();

        // Random phase 2: idle rates swapped, attribute all ones, long hold-off.
        write_attr(8'hFF);
        send_gap_pct  = 47;
        recv_gap_pct <= 37;
        stim_phase   <= 2;
        run_random(PHASE_ITEMS);
        wait_idle();

        // Random phase 3: no idling on either side, random attribute.
        write_attr(8'($urandom_range(1, 254)));
        send_gap_pct  = 0;
        recv_gap_pct <= 0;
        stim_phase   <= 3;
        run_random(PHASE_ITEMS);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests (%0d reads), %0d scrolls, three idle mixes",
                 sent_total, sent_reads, scroll_count);
        $display("Attribute settings: 07 at reset, 00, ff, %02h", last_attr);
        if (fail_count == 0 && outstanding == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
